/* rtl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [12:0] req_bytes;
    logic [11:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] addr;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT0,
    S_INIT1,
    S_IDLE,
    S_RD,
    S_EV,
    S_SPLIT,
    S_FNX,
    S_FPREV,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with header chain kept in a memory with a registered read.
// ----------------------------------------------------------------------------
// One request item gives one response item. After reset the block writes the
// initial headers (states S_INIT0, S_INIT1) before it raises req_ready. Every
// header visited on the chain is handled in two steps (memory read, then
// evaluate); the registered read of the header memory sets that pace. A new
// item is taken once the previous response is loaded into the output register.
`default_nettype none

module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_WORDS = 1024
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic req_valid,
  output logic       req_ready,
  input  wire  req_t req_data,
  output logic       rsp_valid,
  input  wire  logic rsp_ready,
  output rsp_t       rsp_data
);

  localparam int IW = $clog2(HEAP_WORDS);
  localparam int SW = $clog2(HEAP_WORDS + 1);
  localparam int CW = ((IW > 12) ? IW : 12) + 1;
  localparam int WW = ((IW + 3) > 13) ? (IW + 3) : 13;
  localparam logic [IW-1:0] LAST = IW'(HEAP_WORDS - 1);

  // header: {next index, busy}
  logic [IW:0] mem [HEAP_WORDS];
  logic [IW:0] rdata;
  logic [IW-1:0] raddr, waddr;
  logic [IW:0] wdata;
  logic mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  state_t state, state_next;
  logic [1:0]    op, op_next;
  logic [11:0]   need, need_next;
  logic [11:0]   baddr, baddr_next;
  logic [IW-1:0] p, p_next;
  logic [IW-1:0] prev, prev_next;
  logic          prev_busy, prev_busy_next;
  logic          has_prev, has_prev_next;
  logic [SW-1:0] steps, steps_next;
  logic [IW-1:0] split_at, split_at_next;
  logic [IW-1:0] pnext, pnext_next;
  logic          init_reply, init_reply_next;
  logic [1:0]    res_status, res_status_next;
  logic [11:0]   res_addr, res_addr_next;

  logic [IW-1:0] rd_next;
  logic          rd_busy;
  logic [CW-1:0] s, need_c;
  logic [WW-1:0] pay;
  logic [13:0]   bsum;
  logic          load_rsp;

  assign rd_next = rdata[IW:1];
  assign rd_busy = rdata[0];
  assign need_c  = CW'(need);
  assign s       = CW'(rd_next) - CW'(p) - CW'(1);
  assign pay     = WW'({(IW+1)'(p) + (IW+1)'(1), 2'b00});
  assign bsum    = {1'b0, req_data.req_bytes} + 14'd3;
  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
      init_reply <= 1'b0;
    end else begin
      state <= state_next;
      init_reply <= init_reply_next;
    end
    op <= op_next;
    need <= need_next;
    baddr <= baddr_next;
    p <= p_next;
    prev <= prev_next;
    prev_busy <= prev_busy_next;
    has_prev <= has_prev_next;
    steps <= steps_next;
    split_at <= split_at_next;
    pnext <= pnext_next;
    res_status <= res_status_next;
    res_addr <= res_addr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (load_rsp) begin
      rsp_data.status <= res_status;
      rsp_data.addr <= res_addr;
    end
  end

  always_comb begin
    state_next = state;
    op_next = op;
    need_next = need;
    baddr_next = baddr;
    p_next = p;
    prev_next = prev;
    prev_busy_next = prev_busy;
    has_prev_next = has_prev;
    steps_next = steps;
    split_at_next = split_at;
    pnext_next = pnext;
    init_reply_next = init_reply;
    res_status_next = res_status;
    res_addr_next = res_addr;
    mem_we = 1'b0;
    waddr = p;
    wdata = '0;
    raddr = p;
    load_rsp = 1'b0;
    unique case (state)
      S_INIT0: begin
        mem_we = 1'b1;
        waddr = '0;
        wdata = {LAST, 1'b0};
        state_next = S_INIT1;
      end
      S_INIT1: begin
        mem_we = 1'b1;
        waddr = LAST;
        wdata = {{IW{1'b0}}, 1'b1};
        state_next = init_reply ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          op_next = req_data.cmd;
          need_next = bsum[13:2];
          baddr_next = req_data.block_addr;
          p_next = '0;
          prev_next = '0;
          has_prev_next = 1'b0;
          prev_busy_next = 1'b0;
          steps_next = '0;
          res_status_next = ST_DONE;
          res_addr_next = '0;
          priority if (req_data.cmd == CMD_INIT) begin
            init_reply_next = 1'b1;
            state_next = S_INIT0;
          end else if (req_data.cmd == CMD_ALLOC) begin
            if (req_data.req_bytes == '0) begin
              res_status_next = ST_NOFIT;
              state_next = S_DONE;
            end else begin
              state_next = S_RD;
            end
          end else if (req_data.cmd == CMD_FREE) begin
            state_next = (req_data.block_addr == '0) ? S_DONE : S_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_RD: begin
        if (steps == SW'(HEAP_WORDS)) begin
          res_status_next = (op == CMD_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          state_next = S_EV;
        end
      end
      S_EV: begin
        steps_next = steps + SW'(1);
        p_next = rd_next;
        state_next = S_RD;
        if (op == CMD_ALLOC) begin
          if (rd_next == '0) begin
            res_status_next = ST_NOFIT;
            state_next = S_DONE;
          end else if (!rd_busy && (rd_next > p)) begin
            if ((s == need_c) || (s == need_c + CW'(1))) begin
              mem_we = 1'b1;
              wdata = {rd_next, 1'b1};
              res_addr_next = pay[11:0];
              p_next = p;
              state_next = S_DONE;
            end else if (s >= need_c + CW'(2)) begin
              split_at_next = IW'(CW'(p) + need_c + CW'(1));
              pnext_next = rd_next;
              mem_we = 1'b1;
              wdata = {IW'(CW'(p) + need_c + CW'(1)), 1'b1};
              res_addr_next = pay[11:0];
              p_next = p;
              state_next = S_SPLIT;
            end
          end
        end else begin
          if (pay == WW'(baddr)) begin
            p_next = p;
            if (rd_next == '0) begin
              res_status_next = ST_NOTFOUND;
              state_next = S_DONE;
            end else begin
              // clear busy, fetch the following header
              mem_we = 1'b1;
              wdata = {rd_next, 1'b0};
              raddr = rd_next;
              pnext_next = rd_next;
              state_next = S_FNX;
            end
          end else if (rd_next == '0) begin
            res_status_next = ST_NOTFOUND;
            state_next = S_DONE;
          end else begin
            prev_next = p;
            prev_busy_next = rd_busy;
            has_prev_next = 1'b1;
          end
        end
      end
      S_SPLIT: begin
        mem_we = 1'b1;
        waddr = split_at;
        wdata = {pnext, 1'b0};
        state_next = S_DONE;
      end
      S_FNX: begin
        if ((rd_next != '0) && !rd_busy) begin
          mem_we = 1'b1;
          wdata = {rd_next, 1'b0};
          pnext_next = rd_next;
        end
        state_next = S_FPREV;
      end
      S_FPREV: begin
        if (has_prev && !prev_busy) begin
          mem_we = 1'b1;
          waddr = prev;
          wdata = {pnext, 1'b0};
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          load_rsp = 1'b1;
          init_reply_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ffha_checker.sv */
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks for the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_checker
  import ffha_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item taken while one is in work");

  a_addr_only_on_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.addr[1:0] == 2'b00) &&
                  ((rsp_data.status == ST_DONE) || (rsp_data.addr == '0)))
    else $error("bad address in response");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response out of reset");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk(clk), .rst(rst),
  .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

`default_nettype wire
